// File: rtl/ifp_pkg.sv
// ifp_pkg: shared constants for the image fit placement block
// default widths, divider step count, fit mode and register index codes
// no dependencies
`default_nettype none
package ifp_pkg;

  localparam int DIM_BITS  = 16;
  localparam int FRAC_BITS = 16;
  localparam int DIV_STEP  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int MODE_W    = 3;

  localparam logic [MODE_W-1:0] MODE_NONE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WIDTH   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HEIGHT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CONTAIN = 3'd3;
  localparam logic [MODE_W-1:0] MODE_COVER   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_X      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN_Y      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_ORIGIN_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_ORIGIN_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_SIZE_X   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_SIZE_Y   = 3'd6;

endpackage
`default_nettype wire

// File: rtl/ifp_if.sv
// ifp_in_if, ifp_out_if: valid/ready channels of the image fit placement block
// widths default from ifp_pkg
`default_nettype none
interface ifp_in_if #(
  parameter int DIM_BITS = ifp_pkg::DIM_BITS
) ();
  logic                valid;
  logic                ready;
  logic [DIM_BITS-1:0] view_width;
  logic [DIM_BITS-1:0] view_height;
  logic [DIM_BITS-1:0] image_width;
  logic [DIM_BITS-1:0] image_height;

  modport source (output valid, view_width, view_height, image_width, image_height,
                  input ready);
  modport sink (input valid, view_width, view_height, image_width, image_height,
                output ready);
endinterface

interface ifp_out_if #(
  parameter int DIM_BITS  = ifp_pkg::DIM_BITS,
  parameter int FRAC_BITS = ifp_pkg::FRAC_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic                          axis;
  logic [DIM_BITS+FRAC_BITS-1:0] scale;
  logic [DIM_BITS+7:0]           fragment_size;
  logic [DIM_BITS+7:0]           view_origin;
  logic [DIM_BITS+7:0]           view_extent;
  logic [DIM_BITS+7:0]           crop_origin;
  logic [DIM_BITS+7:0]           crop_extent;
  logic [FRAC_BITS:0]            uv_origin;
  logic [FRAC_BITS:0]            uv_extent;
  logic                          saturated;
  logic                          last;

  modport source (output valid, axis, scale, fragment_size, view_origin, view_extent,
                  crop_origin, crop_extent, uv_origin, uv_extent, saturated, last,
                  input ready);
  modport sink (input valid, axis, scale, fragment_size, view_origin, view_extent,
                crop_origin, crop_extent, uv_origin, uv_extent, saturated, last,
                output ready);
endinterface
`default_nettype wire

// File: rtl/ifp_div.sv
// ifp_div: multi-lane pipelined restoring divider with a side payload
// STEP quotient bits per stage; assumes num >> QW < den; uses ifp_pkg
`default_nettype none
module ifp_div #(
  parameter int LANES = 2,
  parameter int NW    = 33,
  parameter int DW    = 16,
  parameter int QW    = 33,
  parameter int SW    = 1,
  parameter int STEP  = ifp_pkg::DIV_STEP
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   num,
  input  logic [LANES-1:0][DW-1:0]   den,
  input  logic [SW-1:0]              side_in,
  output logic                       out_valid,
  output logic [LANES-1:0][QW-1:0]   quo,
  output logic [SW-1:0]              side_out
);
  localparam int LAT = (QW + STEP - 1) / STEP;

  logic [LANES-1:0][DW-1:0] rem_i  [LAT];
  logic [LANES-1:0][QW-1:0] nb_i   [LAT];
  logic [LANES-1:0][DW-1:0] den_i  [LAT];
  logic [SW-1:0]            side_i [LAT];
  logic                     vld_i  [LAT];

  logic [LANES-1:0][DW-1:0] rem_r  [LAT];
  logic [LANES-1:0][QW-1:0] nb_r   [LAT];
  logic [LANES-1:0][DW-1:0] den_r  [LAT];
  logic [SW-1:0]            side_r [LAT];
  logic                     vld_r  [LAT];

  for (genvar g = 0; g < LAT; g++) begin : g_stage
    logic [LANES-1:0][DW-1:0] rem_nxt;
    logic [LANES-1:0][QW-1:0] nb_nxt;

    if (g == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_i[0][l] = DW'(num[l] >> QW);
          nb_i[0][l]  = num[l][QW-1:0];
        end
      end
      assign den_i[0]  = den;
      assign side_i[0] = side_in;
      assign vld_i[0]  = in_valid;
    end else begin : g_next
      assign rem_i[g]  = rem_r[g-1];
      assign nb_i[g]   = nb_r[g-1];
      assign den_i[g]  = den_r[g-1];
      assign side_i[g] = side_r[g-1];
      assign vld_i[g]  = vld_r[g-1];
    end

    always_comb begin
      logic [DW:0]   t;
      logic [DW-1:0] r;
      logic [QW-1:0] b;
      for (int l = 0; l < LANES; l++) begin
        t = '0;
        r = rem_i[g][l];
        b = nb_i[g][l];
        for (int k = 0; k < STEP; k++) begin
          if (g * STEP + k < QW) begin
            t = {r, b[QW-1]};
            b = {b[QW-2:0], t >= {1'b0, den_i[g][l]}};
            if (t >= {1'b0, den_i[g][l]}) begin
              t = t - {1'b0, den_i[g][l]};
            end
            r = t[DW-1:0];
          end
        end
        rem_nxt[l] = r;
        nb_nxt[l]  = b;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= rem_nxt;
        nb_r[g]   <= nb_nxt;
        den_r[g]  <= den_i[g];
        side_r[g] <= side_i[g];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vld_i[g];
      end
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign quo       = nb_r[LAT-1];
  assign side_out  = side_r[LAT-1];

endmodule
`default_nettype wire

// File: rtl/image_fit_placement.sv
// image_fit_placement: fits a texture fragment of an image into a view
// uses ifp_pkg, ifp_in_if, ifp_out_if and ifp_div
//
// usage
//   in_ch carries one item: view and image width and height in pixels.
//   out_ch returns two results per item, x axis then y axis (last set on y).
//   cfg_we/cfg_idx/cfg_data write the fit mode, alignment and texture rectangle;
//   write them only while no item is in flight.
// pipeline
//   the x result leaves the output register first and the y result follows from
//   the same register. the pipeline length is set by the three pipelined
//   dividers (scale quotient, shrunk extent, texture quotients) at two
//   quotient bits per stage.
//   the output register hands out both results of an item before it takes
//   the next item.
// reset
//   the pipeline empties and the registers return to mode none, centered
//   alignment and the full texture.
// stall
//   when out_ch.ready is low the pipeline keeps closing its gaps until a
//   finished item waits behind the output register; then the whole pipeline
//   holds and in_ch.ready drops. nothing is lost.
`default_nettype none
module image_fit_placement #(
  parameter int DIM_BITS  = ifp_pkg::DIM_BITS,
  parameter int FRAC_BITS = ifp_pkg::FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ifp_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [FRAC_BITS:0]            cfg_data,
  ifp_in_if.sink                        in_ch,
  ifp_out_if.source                     out_ch
);
  import ifp_pkg::*;

  localparam int UV_W   = FRAC_BITS + 1;
  localparam int F_W    = DIM_BITS + FRAC_BITS + 1;
  localparam int S_W    = DIM_BITS + FRAC_BITS;
  localparam int PIX_W  = DIM_BITS + 8;
  localparam int VS_W   = DIM_BITS + S_W;
  localparam int CO_W   = F_W + 1;
  localparam int UQ_W   = FRAC_BITS + 2;
  localparam int EXT_NW = F_W + 8;
  localparam int SH     = FRAC_BITS - 8;
  localparam int VOP_W  = PIX_W + UV_W;
  localparam int COP_W  = F_W + UV_W;

  typedef struct packed {
    logic [1:0][DIM_BITS-1:0] v;
    logic [1:0][DIM_BITS-1:0] im;
    logic [1:0][F_W-1:0]      f;
  } p2_t;

  typedef struct packed {
    logic [1:0][DIM_BITS-1:0] v;
    logic [1:0][DIM_BITS-1:0] im;
    logic [1:0][F_W-1:0]      f;
    logic [S_W-1:0]           s;
    logic                     ssat;
    logic                     early;
  } p3_t;

  typedef struct packed {
    logic [1:0][DIM_BITS-1:0] v;
    logic [1:0][DIM_BITS-1:0] im;
    logic [1:0][F_W-1:0]      f;
    logic [S_W-1:0]           s;
    logic                     ssat;
    logic                     early;
    logic [1:0][VS_W-1:0]     vs;
  } p4_t;

  typedef struct packed {
    logic [1:0][DIM_BITS-1:0] v;
    logic [1:0][DIM_BITS-1:0] im;
    logic [1:0][F_W-1:0]      f;
    logic [S_W-1:0]           s;
    logic                     ssat;
    logic                     early;
    logic [1:0][F_W-1:0]      vs_lo;
    logic [1:0]               lt;
    logic [1:0]               gt;
    logic [1:0][F_W-1:0]      diff;
  } p5_t;

  typedef struct packed {
    logic [1:0][DIM_BITS-1:0] im;
    logic [1:0][F_W-1:0]      f;
    logic [S_W-1:0]           s;
    logic                     ssat;
    logic                     early;
    logic [1:0][PIX_W:0]      vo;
    logic [1:0][PIX_W-1:0]    ve;
    logic [1:0][CO_W-1:0]     co;
    logic [1:0][F_W-1:0]      ce;
  } p6_t;

  typedef struct packed {
    logic [S_W-1:0]   scale;
    logic [PIX_W-1:0] frag;
    logic [PIX_W-1:0] vo;
    logic [PIX_W-1:0] ve;
    logic [PIX_W-1:0] co;
    logic [PIX_W-1:0] ce;
    logic [UV_W-1:0]  uo;
    logic [UV_W-1:0]  ue;
    logic             sat;
  } res_t;

  // configuration registers
  logic [MODE_W-1:0]     mode_r;
  logic [1:0][UV_W-1:0]  align_r;
  logic [1:0][UV_W-1:0]  org_r;
  logic [1:0][UV_W-1:0]  size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_NONE;
      align_r[0] <= UV_W'(1) << (FRAC_BITS - 1);
      align_r[1] <= UV_W'(1) << (FRAC_BITS - 1);
      org_r      <= '0;
      size_r[0]  <= UV_W'(1) << FRAC_BITS;
      size_r[1]  <= UV_W'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FIT_MODE:     mode_r     <= cfg_data[MODE_W-1:0];
        REG_ALIGN_X:      align_r[0] <= cfg_data;
        REG_ALIGN_Y:      align_r[1] <= cfg_data;
        REG_TEX_ORIGIN_X: org_r[0]   <= cfg_data;
        REG_TEX_ORIGIN_Y: org_r[1]   <= cfg_data;
        REG_TEX_SIZE_X:   size_r[0]  <= cfg_data;
        REG_TEX_SIZE_Y:   size_r[1]  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic ser_take;

  // stage 1: input register
  logic                     s1_vld_r;
  logic [1:0][DIM_BITS-1:0] s1_v_r;
  logic [1:0][DIM_BITS-1:0] s1_im_r;

  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_v_r  <= {in_ch.view_height, in_ch.view_width};
      s1_im_r <= {in_ch.image_height, in_ch.image_width};
    end
  end

  // stage 2: fragment size
  logic s2_vld_r;
  p2_t  s2_nxt;
  p2_t  s2_r;

  always_comb begin
    s2_nxt.v  = s1_v_r;
    s2_nxt.im = s1_im_r;
    for (int a = 0; a < 2; a++) begin
      s2_nxt.f[a] = F_W'(s1_im_r[a]) * F_W'(size_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

  // fragment / view quotients
  logic                q_vld;
  logic [1:0][F_W-1:0] q_quo;
  p2_t                 q_pay;

  ifp_div #(
    .LANES (2),
    .NW    (F_W),
    .DW    (DIM_BITS),
    .QW    (F_W),
    .SW    ($bits(p2_t))
  ) u_qdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s2_vld_r),
    .num      (s2_r.f),
    .den      (s2_r.v),
    .side_in  (s2_r),
    .out_valid(q_vld),
    .quo      (q_quo),
    .side_out (q_pay)
  );

  // stage 3: scale select and clamp
  logic s3_vld_r;
  p3_t  s3_nxt;
  p3_t  s3_r;

  always_comb begin
    logic [1:0][F_W:0] qe;
    logic [F_W+1:0]    sum;
    logic [F_W:0]      sel;
    for (int a = 0; a < 2; a++) begin
      qe[a] = {~|q_pay.v[a], q_quo[a]};
    end
    sum = (F_W+2)'(qe[0]) + (F_W+2)'(qe[1]);
    s3_nxt.early = 1'b0;
    case (mode_r)
      MODE_NONE: begin
        sel          = sum[F_W+1:1];
        s3_nxt.early = 1'b1;
      end
      MODE_WIDTH:   sel = qe[0];
      MODE_HEIGHT:  sel = qe[1];
      MODE_CONTAIN: sel = (qe[0] > qe[1]) ? qe[0] : qe[1];
      MODE_COVER:   sel = (qe[0] < qe[1]) ? qe[0] : qe[1];
      default:      sel = (F_W+1)'(1) << FRAC_BITS;
    endcase
    s3_nxt.ssat = |sel[F_W:S_W];
    s3_nxt.s    = s3_nxt.ssat ? '1 : sel[S_W-1:0];
    s3_nxt.v    = q_pay.v;
    s3_nxt.im   = q_pay.im;
    s3_nxt.f    = q_pay.f;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= s3_nxt;
    end
  end

  // stage 4: view times scale
  logic s4_vld_r;
  p4_t  s4_nxt;
  p4_t  s4_r;

  always_comb begin
    s4_nxt.v     = s3_r.v;
    s4_nxt.im    = s3_r.im;
    s4_nxt.f     = s3_r.f;
    s4_nxt.s     = s3_r.s;
    s4_nxt.ssat  = s3_r.ssat;
    s4_nxt.early = s3_r.early;
    for (int a = 0; a < 2; a++) begin
      s4_nxt.vs[a] = VS_W'(s3_r.v[a]) * VS_W'(s3_r.s);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r <= s4_nxt;
    end
  end

  // stage 5: shrink or crop decision
  logic s5_vld_r;
  p5_t  s5_nxt;
  p5_t  s5_r;

  always_comb begin
    s5_nxt.v     = s4_r.v;
    s5_nxt.im    = s4_r.im;
    s5_nxt.f     = s4_r.f;
    s5_nxt.s     = s4_r.s;
    s5_nxt.ssat  = s4_r.ssat;
    s5_nxt.early = s4_r.early;
    for (int a = 0; a < 2; a++) begin
      s5_nxt.vs_lo[a] = s4_r.vs[a][F_W-1:0];
      s5_nxt.lt[a]    = !s4_r.early && (VS_W'(s4_r.f[a]) < s4_r.vs[a]);
      s5_nxt.gt[a]    = !s4_r.early && (VS_W'(s4_r.f[a]) > s4_r.vs[a]);
      s5_nxt.diff[a]  = s4_r.f[a] - s4_r.vs[a][F_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r <= s5_nxt;
    end
  end

  // shrunk view extent
  logic                   e_vld;
  logic [1:0][PIX_W-1:0]  e_quo;
  p5_t                    e_pay;
  logic [1:0][EXT_NW-1:0] e_num;

  assign e_num[0] = {s5_r.f[0], 8'd0};
  assign e_num[1] = {s5_r.f[1], 8'd0};

  ifp_div #(
    .LANES (2),
    .NW    (EXT_NW),
    .DW    (S_W),
    .QW    (PIX_W),
    .SW    ($bits(p5_t))
  ) u_ediv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s5_vld_r),
    .num      (e_num),
    .den      ({s5_r.s, s5_r.s}),
    .side_in  (s5_r),
    .out_valid(e_vld),
    .quo      (e_quo),
    .side_out (e_pay)
  );

  // stage 6: aligned offsets
  logic s6_vld_r;
  p6_t  s6_nxt;
  p6_t  s6_r;

  always_comb begin
    logic [PIX_W-1:0] lead;
    logic [VOP_W-1:0] vop;
    logic [COP_W-1:0] cop;
    s6_nxt.im    = e_pay.im;
    s6_nxt.f     = e_pay.f;
    s6_nxt.s     = e_pay.s;
    s6_nxt.ssat  = e_pay.ssat;
    s6_nxt.early = e_pay.early;
    for (int a = 0; a < 2; a++) begin
      lead = {e_pay.v[a], 8'd0} - e_quo[a];
      vop  = VOP_W'(lead) * VOP_W'(align_r[a]);
      cop  = COP_W'(e_pay.diff[a]) * COP_W'(align_r[a]);
      s6_nxt.vo[a] = e_pay.lt[a] ? vop[VOP_W-1:FRAC_BITS] : '0;
      s6_nxt.ve[a] = e_pay.lt[a] ? e_quo[a] : {e_pay.v[a], 8'd0};
      s6_nxt.co[a] = e_pay.gt[a] ? cop[COP_W-1:FRAC_BITS] : '0;
      s6_nxt.ce[a] = e_pay.gt[a] ? e_pay.vs_lo[a] : e_pay.f[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_r <= s6_nxt;
    end
  end

  // texture quotients: lane 2a crop origin, lane 2a+1 crop extent
  logic                     u_vld;
  logic [3:0][UQ_W-1:0]     u_quo;
  p6_t                      u_pay;
  logic [3:0][CO_W-1:0]     u_num;
  logic [3:0][DIM_BITS-1:0] u_den;

  assign u_num = {CO_W'(s6_r.ce[1]), s6_r.co[1], CO_W'(s6_r.ce[0]), s6_r.co[0]};
  assign u_den = {s6_r.im[1], s6_r.im[1], s6_r.im[0], s6_r.im[0]};

  ifp_div #(
    .LANES (4),
    .NW    (CO_W),
    .DW    (DIM_BITS),
    .QW    (UQ_W),
    .SW    ($bits(p6_t))
  ) u_udiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (s6_vld_r),
    .num      (u_num),
    .den      (u_den),
    .side_in  (s6_r),
    .out_valid(u_vld),
    .quo      (u_quo),
    .side_out (u_pay)
  );

  // final clamps
  res_t [1:0] res_nxt;

  always_comb begin
    logic            imz;
    logic [UQ_W-1:0] qo;
    logic [UQ_W-1:0] qe;
    logic [UV_W+1:0] uo;
    logic [UQ_W-1:0] ue;
    logic [F_W-1:0]  fs;
    logic [CO_W-1:0] cs;
    logic [F_W-1:0]  es;
    logic            s_fs, s_vo, s_cs, s_es, s_uo, s_ue;
    for (int a = 0; a < 2; a++) begin
      imz = ~|u_pay.im[a];
      qo  = imz ? '0 : u_quo[2*a];
      qe  = imz ? '0 : u_quo[2*a+1];
      uo  = u_pay.early ? (UV_W+2)'(org_r[a]) : (UV_W+2)'(org_r[a]) + (UV_W+2)'(qo);
      ue  = u_pay.early ? UQ_W'(size_r[a]) : qe;
      fs  = u_pay.f[a] >> SH;
      cs  = u_pay.co[a] >> SH;
      es  = u_pay.ce[a] >> SH;
      s_fs = |fs[F_W-1:PIX_W];
      s_vo = u_pay.vo[a][PIX_W];
      s_cs = |cs[CO_W-1:PIX_W];
      s_es = |es[F_W-1:PIX_W];
      s_uo = |uo[UV_W+1:UV_W];
      s_ue = ue[UV_W];
      res_nxt[a].scale = u_pay.s;
      res_nxt[a].frag  = s_fs ? '1 : fs[PIX_W-1:0];
      res_nxt[a].vo    = s_vo ? '1 : u_pay.vo[a][PIX_W-1:0];
      res_nxt[a].ve    = u_pay.ve[a];
      res_nxt[a].co    = s_cs ? '1 : cs[PIX_W-1:0];
      res_nxt[a].ce    = s_es ? '1 : es[PIX_W-1:0];
      res_nxt[a].uo    = s_uo ? '1 : uo[UV_W-1:0];
      res_nxt[a].ue    = s_ue ? '1 : ue[UV_W-1:0];
      res_nxt[a].sat   = u_pay.ssat | s_fs | s_vo | s_cs | s_es | s_uo | s_ue;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_ch.valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= q_vld;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= e_vld;
    end
  end

  // output register, x result then y result
  logic       out_valid_r;
  logic       phase_r;
  res_t [1:0] res_r;

  assign ser_take = u_vld && (!out_valid_r || (out_ch.ready && phase_r));
  assign en       = !u_vld || ser_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else if (ser_take) begin
      out_valid_r <= 1'b1;
      phase_r     <= 1'b0;
    end else if (out_valid_r && out_ch.ready) begin
      if (phase_r) begin
        out_valid_r <= 1'b0;
        phase_r     <= 1'b0;
      end else begin
        phase_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.axis          = phase_r;
  assign out_ch.last          = phase_r;
  assign out_ch.scale         = res_r[phase_r].scale;
  assign out_ch.fragment_size = res_r[phase_r].frag;
  assign out_ch.view_origin   = res_r[phase_r].vo;
  assign out_ch.view_extent   = res_r[phase_r].ve;
  assign out_ch.crop_origin   = res_r[phase_r].co;
  assign out_ch.crop_extent   = res_r[phase_r].ce;
  assign out_ch.uv_origin     = res_r[phase_r].uo;
  assign out_ch.uv_extent     = res_r[phase_r].ue;
  assign out_ch.saturated     = res_r[phase_r].sat;

endmodule
`default_nettype wire

// File: rtl/ifp_checker.sv
// ifp_checker: port-level checks on the image fit placement block
// bound to image_fit_placement; widths from ifp_pkg
`default_nettype none
module ifp_checker #(
  parameter int SCALE_W = ifp_pkg::DIM_BITS + ifp_pkg::FRAC_BITS
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_axis,
  input wire logic               out_last,
  input wire logic [SCALE_W-1:0] out_scale
);

  // last marks the y result
  a_last_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == out_axis))
    else $error("last does not match axis");

  // y result follows a taken x result
  a_y_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_axis) |=> (out_valid && out_axis))
    else $error("x result not followed by y result");

  // both results of an item share one scale
  a_same_scale: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_axis) |=> (out_scale == $past(out_scale)))
    else $error("scale differs between axes");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_axis) && $stable(out_scale)))
    else $error("stalled result changed");

endmodule

bind image_fit_placement ifp_checker u_ifp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_axis  (out_ch.axis),
  .out_last  (out_ch.last),
  .out_scale (out_ch.scale)
);
`default_nettype wire
